/* sv/ncaa_pkg.sv */
`default_nettype none
package ncaa_pkg;
  localparam int LANE_BITS = 16;
  localparam int VEC_BITS = 64;
  localparam int DIST_BITS = 34;
  localparam int STAT_BITS = 64;
  localparam int DSUM_BITS = 48;
  localparam int CNT_BITS = 32;
  localparam int ACT_BITS = 5;

  typedef enum logic [1:0] {
    OP_OBSERVE = 2'd0,
    OP_SEED    = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]          operation;
    logic [VEC_BITS-1:0] sample_vector;
    logic [3:0]          cluster_index;
    logic [3:0]          stat_index;
  } req_t;

  typedef struct packed {
    logic [3:0]                  assigned_cluster;
    logic [DIST_BITS-1:0]        min_distance;
    logic signed [STAT_BITS-1:0] stat_value;
  } rsp_t;
endpackage
`default_nettype wire

/* sv/ncaa_if.sv */
`default_nettype none
interface ncaa_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/nearest_centroid_assign_accumulate.sv */
// Nearest-centroid assignment with scatter accumulation.
// Channels: in (request: operation, sample_vector, cluster_index, stat_index),
// out (response: assigned_cluster, min_distance, stat_value) and cfg (the
// active cluster count, always ready). Every request gives exactly one response.
// Observe walks the N active seeds one per cycle through the seed memory read
// port, compares the last seed in a final step, then writes the chosen
// cluster's updated accumulator row back. The next request is taken only
// after the response to the previous one has been accepted. A seed write
// responds directly, an accumulator read goes through a read step first, and
// a clear runs the clear pass described below before it responds.
// After reset the accumulator memory is cleared one row a cycle, during which
// no request is accepted; a clear request runs the same pass. Seeds reset to
// zero through a per-entry valid bit.
// The response sits in an output register; while the receiver stalls the
// block holds it and accepts no new request.
`default_nettype none
module nearest_centroid_assign_accumulate
  import ncaa_pkg::*;
#(
  parameter int CLUSTER_SLOTS = 16,
  parameter int DIMS = 4,
  parameter int ELEM_BITS = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  ncaa_if.sink     in_req,
  ncaa_if.source   out_rsp,
  ncaa_if.sink     cfg_wr
);
  localparam int CB = (CLUSTER_SLOTS > 1) ? $clog2(CLUSTER_SLOTS) : 1;
  localparam int CW = $clog2(CLUSTER_SLOTS + 1);
  localparam int TRI = DIMS * (DIMS + 1) / 2;
  localparam int ROW = CNT_BITS + DIMS * DSUM_BITS + TRI * STAT_BITS;
  localparam int SQ = 2 * ELEM_BITS + 2;
  localparam int DB = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int TB = (TRI > 1) ? $clog2(TRI) : 1;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_SCAN, S_LAST, S_UPD, S_RD, S_OUT
  } state_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] cnt;
    logic [DIMS-1:0][DSUM_BITS-1:0] ds;
    logic [TRI-1:0][STAT_BITS-1:0] ss;
  } row_t;

  state_t state_r;
  req_t req_r;
  rsp_t rsp_r;
  logic [ACT_BITS-1:0] act_r;
  logic [CW-1:0] ci_r, ncl_r;
  logic [CB-1:0] best_r;
  logic [DIST_BITS-1:0] bestd_r;
  logic first_r;
  logic [CLUSTER_SLOTS-1:0] sv_r;
  logic svq_r;
  logic [VEC_BITS-1:0] seed_mem [CLUSTER_SLOTS];
  logic [VEC_BITS-1:0] seedq_r;
  logic [ROW-1:0] acc_mem [CLUSTER_SLOTS];
  logic [ROW-1:0] accq_r;
  logic [CB-1:0] acc_ra, acc_wa;
  logic acc_we;
  logic [ROW-1:0] acc_wd;
  logic [CB-1:0] seed_ra;

  req_t in_d;
  logic [DB-1:0] ds_idx;
  logic [TB-1:0] ss_idx;
  logic signed [ELEM_BITS-1:0] v [DIMS];
  logic signed [ELEM_BITS-1:0] s [DIMS];
  logic [DIST_BITS-1:0] sq_dist;
  row_t rd_row, wr_row;

  assign in_d = req_t'(in_req.data);
  assign ds_idx = DB'(req_r.stat_index - 4'd1);
  assign ss_idx = TB'(req_r.stat_index - 4'(DIMS + 1));

  assign in_req.ready = (state_r == S_IDLE);
  assign cfg_wr.ready = 1'b1;
  assign out_rsp.valid = (state_r == S_OUT);
  assign out_rsp.data = rsp_r;

  always_comb begin
    logic [SQ-1:0] sq;
    logic signed [ELEM_BITS:0] df;
    sq_dist = '0;
    for (int d = 0; d < DIMS; d++) begin
      v[d] = req_r.sample_vector[d*LANE_BITS +: ELEM_BITS];
      s[d] = svq_r ? seedq_r[d*LANE_BITS +: ELEM_BITS] : '0;
      df = (ELEM_BITS+1)'(s[d]) - (ELEM_BITS+1)'(v[d]);
      sq = SQ'($signed(df) * $signed(df));
      sq_dist = sq_dist + DIST_BITS'(sq);
    end
  end

  always_comb begin
    logic signed [DSUM_BITS:0] t;
    logic signed [STAT_BITS:0] u;
    logic signed [2*ELEM_BITS-1:0] p;
    int k;
    rd_row = accq_r;
    wr_row = rd_row;
    k = 0;
    if (rd_row.cnt != '1) wr_row.cnt = rd_row.cnt + 1'b1;
    for (int d = 0; d < DIMS; d++) begin
      t = $signed({rd_row.ds[d][DSUM_BITS-1], rd_row.ds[d]}) + (DSUM_BITS+1)'(v[d]);
      if (t[DSUM_BITS] != t[DSUM_BITS-1])
        wr_row.ds[d] = t[DSUM_BITS] ? {1'b1, {(DSUM_BITS-1){1'b0}}}
                                    : {1'b0, {(DSUM_BITS-1){1'b1}}};
      else wr_row.ds[d] = t[DSUM_BITS-1:0];
    end
    for (int r = 0; r < DIMS; r++) begin
      for (int c = 0; c <= r; c++) begin
        p = v[r] * v[c];
        u = $signed({rd_row.ss[k][STAT_BITS-1], rd_row.ss[k]}) + (STAT_BITS+1)'(p);
        if (u[STAT_BITS] != u[STAT_BITS-1])
          wr_row.ss[k] = u[STAT_BITS] ? {1'b1, {(STAT_BITS-1){1'b0}}}
                                      : {1'b0, {(STAT_BITS-1){1'b1}}};
        else wr_row.ss[k] = u[STAT_BITS-1:0];
        k++;
      end
    end
  end

  always_comb begin
    seed_ra = ci_r[CB-1:0];
    acc_ra = (state_r == S_IDLE) ? CB'(in_d.cluster_index) : best_r;
    if (state_r == S_LAST)
      acc_ra = (sq_dist < bestd_r || first_r) ? ci_r[CB-1:0] - 1'b1 : best_r;
    acc_we = (state_r == S_CLR) || (state_r == S_UPD);
    acc_wa = (state_r == S_CLR) ? ci_r[CB-1:0] : best_r;
    acc_wd = (state_r == S_CLR) ? '0 : wr_row;
  end

  always_ff @(posedge clk) begin
    seedq_r <= seed_mem[seed_ra];
    svq_r <= sv_r[seed_ra];
    accq_r <= acc_mem[acc_ra];
    if (acc_we) acc_mem[acc_wa] <= acc_wd;
    if (state_r == S_IDLE && in_req.valid && in_d.operation == OP_SEED &&
        32'(in_d.cluster_index) < CLUSTER_SLOTS)
      seed_mem[CB'(in_d.cluster_index)] <= in_d.sample_vector;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      act_r <= ACT_BITS'(1);
      ci_r <= '0;
      sv_r <= '0;
      first_r <= 1'b0;
    end else begin
      if (cfg_wr.valid) act_r <= cfg_wr.data[ACT_BITS-1:0];
      unique case (state_r)
        S_CLR: begin
          ci_r <= ci_r + 1'b1;
          if (ci_r == CW'(CLUSTER_SLOTS - 1)) begin
            rsp_r <= '0;
            state_r <= first_r ? S_OUT : S_IDLE;
            first_r <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_req.valid) begin
            req_r <= in_d;
            rsp_r <= '0;
            ci_r <= '0;
            first_r <= 1'b1;
            if (act_r == '0) ncl_r <= CW'(1);
            else if (32'(act_r) > CLUSTER_SLOTS) ncl_r <= CW'(CLUSTER_SLOTS);
            else ncl_r <= CW'(act_r);
            unique case (op_t'(in_d.operation))
              OP_OBSERVE: state_r <= S_SCAN;
              OP_SEED: begin
                if (32'(in_d.cluster_index) < CLUSTER_SLOTS)
                  sv_r[CB'(in_d.cluster_index)] <= 1'b1;
                state_r <= S_OUT;
              end
              OP_CLEAR: state_r <= S_CLR;
              OP_READ: state_r <= S_RD;
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_SCAN: begin
          ci_r <= ci_r + 1'b1;
          if (ci_r + 1'b1 == ncl_r) state_r <= S_LAST;
          if (ci_r != '0) begin
            if (first_r || sq_dist < bestd_r) begin
              bestd_r <= sq_dist;
              best_r <= CB'(ci_r - 1'b1);
            end
            first_r <= 1'b0;
          end
        end
        S_LAST: begin
          if (first_r || sq_dist < bestd_r) begin
            bestd_r <= sq_dist;
            best_r <= CB'(ci_r - 1'b1);
          end
          first_r <= 1'b0;
          state_r <= S_UPD;
        end
        S_UPD: begin
          rsp_r.assigned_cluster <= 4'(best_r);
          rsp_r.min_distance <= bestd_r;
          state_r <= S_OUT;
        end
        S_RD: begin
          if (32'(req_r.cluster_index) < CLUSTER_SLOTS) begin
            if (req_r.stat_index == 4'd0)
              rsp_r.stat_value <= STAT_BITS'(rd_row.cnt);
            else if (32'(req_r.stat_index) <= DIMS)
              rsp_r.stat_value <= STAT_BITS'($signed(rd_row.ds[ds_idx]));
            else if (32'(req_r.stat_index) <= DIMS + TRI)
              rsp_r.stat_value <= rd_row.ss[ss_idx];
          end
          state_r <= S_OUT;
        end
        S_OUT: if (out_rsp.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_req.ready && out_rsp.valid)) else $error("accept while response pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && !out_rsp.ready |=> out_rsp.valid && $stable(rsp_r))
    else $error("response dropped");
  a_best: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |-> 32'(best_r) < CLUSTER_SLOTS) else $error("bad best");
`endif
endmodule
`default_nettype wire
